>>> rtl/core/cfc_pkg.sv
`timescale 1ns / 1ps
// Package for the text stream filter core: character codes, register indexes,
// numbering modes, configuration and job types. Depends on nothing.
package cfc_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_QMARK  = 8'h3F;
   localparam logic [7:0] CH_I      = 8'h49;
   localparam logic [7:0] CH_M      = 8'h4D;
   localparam logic [7:0] CH_CARET  = 8'h5E;

   localparam logic [7:0] CTRL_LAST  = 8'd31;
   localparam logic [7:0] CH_DEL     = 8'd127;
   localparam logic [7:0] META_CTRL  = 8'd159;
   localparam logic [7:0] META_LAST  = 8'd254;
   localparam logic [7:0] CTRL_SHIFT = 8'd64;
   localparam logic [7:0] META_SHIFT = 8'd128;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NUMBERING_MODE   = 3'd0,
      CSR_SQUEEZE_BLANK    = 3'd1,
      CSR_SHOW_ENDS        = 3'd2,
      CSR_SHOW_TABS        = 3'd3,
      CSR_SHOW_NONPRINTING = 3'd4
   } cfc_csr_index_type;

   typedef enum logic [1:0] {
      MODE_NONE     = 2'd0,
      MODE_ALL      = 2'd1,
      MODE_NONBLANK = 2'd2
   } cfc_mode_type;

   typedef struct packed {
      logic [1:0] numbering_mode;
      logic       squeeze_blank;
      logic       show_ends;
      logic       show_tabs;
      logic       show_nonprinting;
   } cfc_cfg_type;

   // Rendered bytes of one input word; chars[0] goes out first.
   typedef struct packed {
      logic             has_number;
      logic [2:0]       len;
      logic [3:0][7:0]  chars;
   } cfc_job_type;

   localparam int JOB_W = $bits(cfc_job_type);

endpackage

>>> rtl/core/cfc_queue.sv
`timescale 1ns / 1ps
// Small register queue that decouples the classifier from the output sequencer.
// Depends on nothing.
module cfc_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             full,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign rdata = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

>>> rtl/core/cfc_front.sv
`timescale 1ns / 1ps
// Front end: accepts input words, tracks line state and the BCD line counter,
// and turns each unsqueezed word into a job for the queue. Depends on cfc_pkg.
module cfc_front import cfc_pkg::*; #(
   parameter int NUMBER_DIGITS = 6
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cfc_cfg_type                  cfg,
   input  logic                         req_valid,
   input  logic                         q_full,
   input  logic [7:0]                   req_in_byte,
   output logic                         push,
   output cfc_job_type                  job,
   output logic [4*NUMBER_DIGITS-1:0]   digits
);
   localparam int CNT_W = 4 * NUMBER_DIGITS;

   logic             at_start_ff, at_start_in;
   logic             prev_blank_ff, prev_blank_in;
   logic             cur_blank_ff, cur_blank_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic accept, is_nl, is_tab, squeeze, number, all_mode, nb_mode, nonprint;
   logic all_nines, carry;
   logic [CNT_W-1:0] count_inc;
   logic [3:0] d;

   assign accept = req_valid && !q_full;
   assign is_nl  = (req_in_byte == CH_NL);
   assign is_tab = (req_in_byte == CH_TAB);
   assign squeeze = is_nl && cur_blank_ff && prev_blank_ff && cfg.squeeze_blank;
   assign push   = accept && !squeeze;
   assign digits = count_ff;

   always_comb begin
      all_mode = 1'b0;
      nb_mode  = 1'b0;
      case (cfg.numbering_mode)
         MODE_NONE: ;
         MODE_ALL:  all_mode = 1'b1;
         default:   nb_mode  = 1'b1;
      endcase
   end

   assign number = at_start_ff && (all_mode || (nb_mode && !is_nl));
   assign nonprint = cfg.show_nonprinting &&
                     ((req_in_byte <= CTRL_LAST && !is_tab && !is_nl) ||
                      req_in_byte >= CH_DEL);

   always_comb begin
      all_nines = 1'b1;
      carry     = 1'b1;
      count_inc = count_ff;
      d         = '0;
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
         if (count_ff[4*i +: 4] != 4'd9) begin
            all_nines = 1'b0;
         end
      end
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
         d = count_ff[4*i +: 4];
         if (carry) begin
            count_inc[4*i +: 4] = (d >= 4'd9) ? 4'd0 : 4'(d + 4'd1);
         end
         carry = carry && (d >= 4'd9);
      end
      if (all_nines) begin
         count_inc = count_ff;
      end
   end

   always_comb begin
      job            = '0;
      job.has_number = number;
      job.len        = 3'd1;
      job.chars[0]   = req_in_byte;
      if (nonprint) begin
         if (req_in_byte <= CTRL_LAST) begin
            job.len      = 3'd2;
            job.chars[0] = CH_CARET;
            job.chars[1] = 8'(req_in_byte + CTRL_SHIFT);
         end else if (req_in_byte == CH_DEL) begin
            job.len      = 3'd2;
            job.chars[0] = CH_CARET;
            job.chars[1] = CH_QMARK;
         end else begin
            job.chars[0] = CH_M;
            job.chars[1] = CH_DASH;
            if (req_in_byte <= META_CTRL) begin
               job.len      = 3'd4;
               job.chars[2] = CH_CARET;
               job.chars[3] = 8'(req_in_byte - CTRL_SHIFT);
            end else if (req_in_byte <= META_LAST) begin
               job.len      = 3'd3;
               job.chars[2] = 8'(req_in_byte - META_SHIFT);
            end else begin
               job.len      = 3'd4;
               job.chars[2] = CH_CARET;
               job.chars[3] = CH_QMARK;
            end
         end
      end else if (cfg.show_tabs && is_tab) begin
         job.len      = 3'd2;
         job.chars[0] = CH_CARET;
         job.chars[1] = CH_I;
      end else if (cfg.show_ends && is_nl) begin
         job.len      = 3'd2;
         job.chars[0] = CH_DOLLAR;
         job.chars[1] = CH_NL;
      end
   end

   always_comb begin
      at_start_in   = at_start_ff;
      prev_blank_in = prev_blank_ff;
      cur_blank_in  = cur_blank_ff;
      count_in      = count_ff;
      if (push) begin
         if (is_nl) begin
            if (cur_blank_ff) begin
               prev_blank_in = 1'b1;
            end else begin
               prev_blank_in = 1'b0;
               cur_blank_in  = 1'b1;
            end
         end else begin
            cur_blank_in = 1'b0;
         end
         if (number) begin
            count_in    = count_inc;
            at_start_in = 1'b0;
         end
         if (is_nl) begin
            at_start_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_start_ff   <= 1'b1;
         prev_blank_ff <= 1'b0;
         cur_blank_ff  <= 1'b1;
         count_ff      <= CNT_W'(1);
      end else begin
         at_start_ff   <= at_start_in;
         prev_blank_ff <= prev_blank_in;
         cur_blank_ff  <= cur_blank_in;
         count_ff      <= count_in;
      end
   end

endmodule

>>> rtl/core/cfc_back.sv
`timescale 1ns / 1ps
// Back end: walks the job at the queue head and sends one rendered word per
// cycle while rsp_stall is low, through the output register. Depends on cfc_pkg.
module cfc_back import cfc_pkg::*; #(
   parameter int NUMBER_DIGITS = 6
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_empty,
   input  cfc_job_type                  head_job,
   input  logic [4*NUMBER_DIGITS-1:0]   head_digits,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [7:0]                   rsp_out_byte,
   output logic                         rsp_last_of_run
);
   localparam int PW   = $clog2(NUMBER_DIGITS + 6);
   localparam int DI_W = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;

   logic [PW-1:0] pos_ff, pos_in;
   logic          seen_ff, seen_in;
   logic          valid_ff, valid_in;
   logic [7:0]    byte_ff, byte_in;
   logic          last_ff, last_in;

   logic            out_ready, take, last, seen_next;
   logic [PW-1:0]   sel, rel;
   logic [DI_W-1:0] didx;
   logic [3:0]      d;

   assign out_ready = !valid_ff || !rsp_stall;
   assign take      = out_ready && !q_empty;
   assign sel = head_job.has_number ? pos_ff : PW'(pos_ff + PW'(NUMBER_DIGITS + 1));
   assign last = (sel == PW'(PW'(NUMBER_DIGITS) + PW'(head_job.len)));
   assign rel  = PW'(sel - PW'(NUMBER_DIGITS + 1));
   assign didx = DI_W'(PW'(NUMBER_DIGITS - 1) - sel);
   assign pop  = take && last;

   always_comb begin
      d = head_digits[4*didx +: 4];
      if (d > 4'd9) begin
         d = 4'd9;
      end
      seen_next = seen_ff || (d != 4'd0);
      if (sel < PW'(NUMBER_DIGITS)) begin
         byte_in = (!seen_next && didx != '0) ? CH_SPACE : (CH_ZERO | {4'd0, d});
      end else if (sel == PW'(NUMBER_DIGITS)) begin
         byte_in = CH_TAB;
      end else begin
         byte_in = head_job.chars[rel[1:0]];
      end
   end

   always_comb begin
      pos_in   = pos_ff;
      seen_in  = seen_ff;
      valid_in = valid_ff;
      last_in  = last;
      if (out_ready) begin
         valid_in = take;
      end
      if (take) begin
         if (last) begin
            pos_in  = '0;
            seen_in = 1'b0;
         end else begin
            pos_in  = PW'(pos_ff + 1'b1);
            seen_in = seen_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         seen_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         seen_ff  <= seen_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= byte_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_last_of_run = last_ff;

endmodule

>>> rtl/core/text_stream_cat_filter_core.sv
`timescale 1ns / 1ps
// Top level of the text stream filter: configuration registers, front end,
// job queue and back end. Depends on cfc_pkg, cfc_front, cfc_queue, cfc_back.
//
//   channel   direction  handshake          payload
//   req_      in         valid / stall      in_byte
//   rsp_      out        valid / stall      out_byte, last_of_run
//   csr_      in         valid / ready      index, data
//
// A plain word is taken every cycle while req_stall is low; its rendering goes through
// the job queue and the output register. A numbered line start adds NUMBER_DIGITS + 1
// words and a shown control or high byte up to four, all sent by the back end one per
// cycle while rsp_stall is low; the four-entry job queue stalls the input once it fills.
// A squeezed newline is taken and gives no word. Reset is synchronous.
module text_stream_cat_filter_core import cfc_pkg::*; #(
   parameter int NUMBER_DIGITS = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_in_byte,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_last_of_run,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);
   localparam int DIG_W = 4 * NUMBER_DIGITS;
   localparam int Q_W   = DIG_W + JOB_W;

   cfc_cfg_type cfg_ff, cfg_in;

   logic             q_push, q_pop, q_full, q_empty;
   cfc_job_type      f_job, h_job;
   logic [DIG_W-1:0] f_digits, h_digits;
   logic [Q_W-1:0]   q_rdata;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_NUMBERING_MODE:   cfg_in.numbering_mode   = csr_data[1:0];
            CSR_SQUEEZE_BLANK:    cfg_in.squeeze_blank    = csr_data[0];
            CSR_SHOW_ENDS:        cfg_in.show_ends        = csr_data[0];
            CSR_SHOW_TABS:        cfg_in.show_tabs        = csr_data[0];
            CSR_SHOW_NONPRINTING: cfg_in.show_nonprinting = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cfc_front #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .q_full      (q_full),
      .req_in_byte (req_in_byte),
      .push        (q_push),
      .job         (f_job),
      .digits      (f_digits)
   );

   cfc_queue #(.WIDTH(Q_W), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata ({f_digits, f_job}),
      .pop   (q_pop),
      .rdata (q_rdata),
      .full  (q_full),
      .empty (q_empty)
   );

   assign h_digits = q_rdata[Q_W-1:JOB_W];
   assign h_job    = q_rdata[JOB_W-1:0];

   cfc_back #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .head_job        (h_job),
      .head_digits     (h_digits),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full)) else $error("job pushed into a full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_empty)) else $error("job popped from an empty queue");

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      q_push |=> !q_empty) else $error("pushed job not visible in the queue");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("output word valid right after reset");

endmodule
